@@ hdl/ssgd_pkg.sv @@
// ============================================================================
// ssgd_pkg - shared types and constants for the scalar SGD regressor
// Command codes, register indexes, sequencer states and the request struct
// that drives the serial multiplier.
// ============================================================================
package ssgd_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Gradient sums and wide intermediates are fixed at 64 bits.
  localparam int SUM_W     = 64;
  // Sample counter width; also the divisor width.
  localparam int COUNT_W   = 32;
  // Width and fraction bits of learn_rate and the decay factors (Q0.16).
  localparam int RATE_W    = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [RATE_W-1:0] LEARN_RATE_RST = 16'd655;

  typedef enum logic [1:0] {
    CMD_PREDICT = 2'd0,
    CMD_OBSERVE = 2'd1,
    CMD_UPDATE  = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_WEIGHT = 3'd0,
    REG_START_BIAS   = 3'd1,
    REG_LEARN_RATE   = 3'd2,
    REG_WEIGHT_DECAY = 3'd3,
    REG_BIAS_DECAY   = 3'd4,
    REG_INPUT_CLAMP  = 3'd5,
    REG_FROZEN       = 3'd6
  } cfg_reg_t;

  // Right shift applied to a finished product.
  typedef enum logic [1:0] {
    SH_FRAC    = 2'd0,
    SH_FRAC_M1 = 2'd1,
    SH_RATE    = 2'd2
  } shift_sel_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_MUL_WAIT,
    ST_PRED_ADD,
    ST_ERR,
    ST_DW_START,
    ST_WSUM,
    ST_DB,
    ST_BSUM,
    ST_GW,
    ST_DIVW_START,
    ST_DIV_WAIT,
    ST_STW,
    ST_WNEW,
    ST_BDEC,
    ST_GB,
    ST_DIVB_START,
    ST_STB,
    ST_BNEW,
    ST_DONE
  } state_t;

  // start: load operands and begin; short_op: multiplier is a Q0.16 factor
  // that only needs RATE_W steps.
  typedef struct packed {
    logic start;
    logic short_op;
  } mul_req_t;

endpackage

@@ hdl/scalar_sgd_linear_regressor_core.sv @@
// ============================================================================
// scalar_sgd_linear_regressor_core - single-feature linear predictor, SGD
// Predicts x*w+b and trains w, b by batched gradient descent in signed
// fixed point with saturation, using one serial multiplier and one serial
// divider under a sequencer.
// ============================================================================
//
//  channel | handshake           | payload
//  --------+---------------------+---------------------------------------------
//  in      | in_valid / in_stall | in_command, in_sample_x, in_snap_weight,
//          |                     | in_snap_bias, in_actual_value
//  out     | out_valid/out_stall | out_predicted, out_weight_now, out_bias_now,
//          |                     | out_accepted
//  cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data (cfg_ready is always 1)
//
//  Work per transfer, from input accept to result ready:
//    predict  one serial multiplier pass (1 bit/cycle)
//    observe  two multiplier passes; none when dropped
//    update   four short multiplier passes and two
//             divider passes; none when frozen or the count is zero
//    restart  no multiplier or divider pass
//  Reset is synchronous and active low; it restores model state and registers.
//  A new input is taken while an earlier result still waits on out_stall.
// ============================================================================
module scalar_sgd_linear_regressor_core #(
  parameter int DATA_WIDTH = ssgd_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = ssgd_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_command,
  input  logic signed [DATA_WIDTH-1:0]      in_sample_x,
  input  logic signed [DATA_WIDTH-1:0]      in_snap_weight,
  input  logic signed [DATA_WIDTH-1:0]      in_snap_bias,
  input  logic signed [DATA_WIDTH-1:0]      in_actual_value,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [DATA_WIDTH-1:0]      out_predicted,
  output logic signed [DATA_WIDTH-1:0]      out_weight_now,
  output logic signed [DATA_WIDTH-1:0]      out_bias_now,
  output logic                              out_accepted,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ssgd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [DATA_WIDTH-1:0]             cfg_data
);

  localparam int SW    = ssgd_pkg::SUM_W;
  localparam int CW    = ssgd_pkg::COUNT_W;
  localparam int RW    = ssgd_pkg::RATE_W;
  localparam int PW    = SW + DATA_WIDTH;
  localparam int ADD_W = SW + 2;
  localparam int SUM_X = ADD_W + 1;

  // Saturation bounds, held at 64 bits.
  localparam logic signed [SW-1:0] DMAX_W = SW'({1'b0, {(DATA_WIDTH-1){1'b1}}});
  localparam logic signed [SW-1:0] DMIN_W = ~DMAX_W;
  localparam logic signed [SW-1:0] SMAX_W = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN_W = ~SMAX_W;
  localparam logic signed [DATA_WIDTH-1:0] CLAMP_RST = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [DATA_WIDTH-1:0] start_weight_r, start_bias_r, input_clamp_r;
  logic [RW-1:0]                learn_rate_r, weight_decay_r, bias_decay_r;
  logic                         frozen_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_weight_r <= '0;
      start_bias_r   <= '0;
      learn_rate_r   <= ssgd_pkg::LEARN_RATE_RST;
      weight_decay_r <= '0;
      bias_decay_r   <= '0;
      input_clamp_r  <= CLAMP_RST;
      frozen_r       <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        ssgd_pkg::REG_START_WEIGHT: start_weight_r <= cfg_data;
        ssgd_pkg::REG_START_BIAS:   start_bias_r   <= cfg_data;
        ssgd_pkg::REG_LEARN_RATE:   learn_rate_r   <= cfg_data[RW-1:0];
        ssgd_pkg::REG_WEIGHT_DECAY: weight_decay_r <= cfg_data[RW-1:0];
        ssgd_pkg::REG_BIAS_DECAY:   bias_decay_r   <= cfg_data[RW-1:0];
        ssgd_pkg::REG_INPUT_CLAMP:  input_clamp_r  <= cfg_data;
        ssgd_pkg::REG_FROZEN:       frozen_r       <= cfg_data[0];
        default: ;  // unknown index: drop the write
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Model state, sequencer and working registers
  // --------------------------------------------------------------------------
  ssgd_pkg::state_t state_r, state_nxt, ret_r, ret_nxt;

  logic signed [DATA_WIDTH-1:0] weight_r, weight_nxt, bias_r, bias_nxt;
  logic [CW-1:0]                count_r, count_nxt;
  logic signed [SW-1:0]         wsum_r, wsum_nxt, bsum_r, bsum_nxt;
  logic                         ok_r, ok_nxt;

  // captured input transfer
  ssgd_pkg::cmd_t               cmd_r;
  logic signed [DATA_WIDTH-1:0] x_r, sw_r, sb_r, act_r;

  // scratch value and observation error
  logic signed [SW-1:0]         t_r, t_nxt;
  logic signed [DATA_WIDTH-1:0] err_r, err_nxt;

  // how to finish the product in flight
  logic                         mneg_r, mneg_nxt, mdata_r, mdata_nxt;
  ssgd_pkg::shift_sel_t         msh_r, msh_nxt;

  // result register
  logic                         out_valid_r, out_valid_nxt, out_load;
  logic signed [DATA_WIDTH-1:0] out_pred_r, out_w_r, out_b_r;
  logic                         out_ok_r;

  logic in_fire;
  assign in_stall = (state_r != ssgd_pkg::ST_IDLE);
  assign in_fire  = in_valid && !in_stall;

  // --------------------------------------------------------------------------
  // Magnitudes and signs of multiplier operands
  // --------------------------------------------------------------------------
  logic signed [DATA_WIDTH-1:0] xc;
  logic [DATA_WIDTH-1:0]        w_mag, b_mag, x_mag, xc_mag, err_mag;
  logic [SW-1:0]                t_mag;

  assign xc      = (x_r < input_clamp_r) ? x_r : input_clamp_r;
  assign w_mag   = weight_r[DATA_WIDTH-1] ? DATA_WIDTH'(-weight_r) : DATA_WIDTH'(weight_r);
  assign b_mag   = bias_r[DATA_WIDTH-1]   ? DATA_WIDTH'(-bias_r)   : DATA_WIDTH'(bias_r);
  assign x_mag   = x_r[DATA_WIDTH-1]      ? DATA_WIDTH'(-x_r)      : DATA_WIDTH'(x_r);
  assign xc_mag  = xc[DATA_WIDTH-1]       ? DATA_WIDTH'(-xc)       : DATA_WIDTH'(xc);
  assign err_mag = err_r[DATA_WIDTH-1]    ? DATA_WIDTH'(-err_r)    : DATA_WIDTH'(err_r);
  assign t_mag   = t_r[SW-1]              ? SW'(-t_r)              : SW'(t_r);

  // --------------------------------------------------------------------------
  // Serial multiplier and divider
  // --------------------------------------------------------------------------
  ssgd_pkg::mul_req_t    mul_req;
  logic                  mul_start, mul_short, mul_done;
  logic [SW-1:0]         mul_a;
  logic [DATA_WIDTH-1:0] mul_b;
  logic [PW-1:0]         mul_prod;

  logic                  div_start, div_done;
  logic [SW-1:0]         div_quot;

  assign mul_req = '{start: mul_start, short_op: mul_short};

  ssgd_mul #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (mul_req),
    .a_mag  (mul_a),
    .b_mag  (mul_b),
    .done   (mul_done),
    .product(mul_prod)
  );

  ssgd_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(t_mag),
    .divisor (count_r),
    .done    (div_done),
    .quotient(div_quot)
  );

  // Finish a product: shift right with floor rounding, then saturate to
  // either the data range or the 64-bit range.
  logic [PW-1:0]        q_sel, q_adj, lim_pos, lim;
  logic                 rem_sel;
  logic [SW-1:0]        sat_mag;
  logic signed [SW-1:0] msat;

  always_comb begin
    case (msh_r)
      ssgd_pkg::SH_FRAC_M1: begin
        q_sel   = mul_prod >> (FRAC_BITS - 1);
        rem_sel = |mul_prod[FRAC_BITS-2:0];
      end
      ssgd_pkg::SH_RATE: begin
        q_sel   = mul_prod >> RW;
        rem_sel = |mul_prod[RW-1:0];
      end
      default: begin
        q_sel   = mul_prod >> FRAC_BITS;
        rem_sel = |mul_prod[FRAC_BITS-1:0];
      end
    endcase
    // negative results round away from zero in magnitude (floor)
    q_adj   = q_sel + PW'(mneg_r & rem_sel);
    lim_pos = mdata_r ? PW'(DMAX_W) : PW'(SMAX_W);
    lim     = lim_pos + PW'(mneg_r);
    sat_mag = (q_adj > lim) ? lim[SW-1:0] : q_adj[SW-1:0];
    msat    = mneg_r ? -$signed(sat_mag) : $signed(sat_mag);
  end

  // --------------------------------------------------------------------------
  // Shared saturating adder; operand selection follows the sequencer state
  // --------------------------------------------------------------------------
  logic signed [ADD_W-1:0] add_a, add_b, err_x;
  logic                    add_sub, add_data;
  logic signed [SUM_X-1:0] add_sum, add_hi, add_lo;
  logic signed [SW-1:0]    add_res;

  assign err_x = ADD_W'(err_r);

  always_comb begin
    add_a    = '0;
    add_b    = '0;
    add_sub  = 1'b0;
    add_data = 1'b0;
    mul_a    = SW'(w_mag);
    mul_b    = x_mag;
    mul_short = 1'b0;
    case (state_r)
      ssgd_pkg::ST_DISPATCH: begin
        if (cmd_r == ssgd_pkg::CMD_UPDATE) begin
          mul_b     = DATA_WIDTH'(weight_decay_r);
          mul_short = 1'b1;
        end
      end
      ssgd_pkg::ST_DW_START: begin
        mul_a = SW'(xc_mag);
        mul_b = err_mag;
      end
      ssgd_pkg::ST_STW, ssgd_pkg::ST_STB: begin
        mul_a     = t_mag;
        mul_b     = DATA_WIDTH'(learn_rate_r);
        mul_short = 1'b1;
      end
      ssgd_pkg::ST_BDEC: begin
        mul_a     = SW'(b_mag);
        mul_b     = DATA_WIDTH'(bias_decay_r);
        mul_short = 1'b1;
      end
      ssgd_pkg::ST_PRED_ADD: begin
        add_a    = ADD_W'(t_r);
        add_b    = ADD_W'(bias_r);
        add_data = 1'b1;
      end
      ssgd_pkg::ST_ERR: begin
        add_a    = ADD_W'(act_r);
        add_b    = ADD_W'(t_r);
        add_sub  = 1'b1;
        add_data = 1'b1;
      end
      ssgd_pkg::ST_WSUM, ssgd_pkg::ST_GW: begin
        add_a = ADD_W'(wsum_r);
        add_b = ADD_W'(t_r);
      end
      ssgd_pkg::ST_DB: begin
        add_b   = err_x <<< 1;
        add_sub = 1'b1;
      end
      ssgd_pkg::ST_BSUM, ssgd_pkg::ST_GB: begin
        add_a = ADD_W'(bsum_r);
        add_b = ADD_W'(t_r);
      end
      ssgd_pkg::ST_WNEW: begin
        add_a    = ADD_W'(weight_r);
        add_b    = ADD_W'(t_r);
        add_sub  = 1'b1;
        add_data = 1'b1;
      end
      ssgd_pkg::ST_BNEW: begin
        add_a    = ADD_W'(bias_r);
        add_b    = ADD_W'(t_r);
        add_sub  = 1'b1;
        add_data = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    add_sum = add_sub ? SUM_X'(add_a) - SUM_X'(add_b) : SUM_X'(add_a) + SUM_X'(add_b);
    add_hi  = add_data ? SUM_X'(DMAX_W) : SUM_X'(SMAX_W);
    add_lo  = add_data ? SUM_X'(DMIN_W) : SUM_X'(SMIN_W);
    if (add_sum > add_hi) begin
      add_res = add_hi[SW-1:0];
    end else if (add_sum < add_lo) begin
      add_res = add_lo[SW-1:0];
    end else begin
      add_res = add_sum[SW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: next state and datapath controls
  // --------------------------------------------------------------------------
  logic obs_drop, upd_skip;
  assign obs_drop = frozen_r || (sw_r != weight_r) || (sb_r != bias_r);
  assign upd_skip = frozen_r || (count_r == '0);

  always_comb begin
    state_nxt  = state_r;
    ret_nxt    = ret_r;
    t_nxt      = t_r;
    err_nxt    = err_r;
    weight_nxt = weight_r;
    bias_nxt   = bias_r;
    count_nxt  = count_r;
    wsum_nxt   = wsum_r;
    bsum_nxt   = bsum_r;
    ok_nxt     = ok_r;
    mneg_nxt   = mneg_r;
    msh_nxt    = msh_r;
    mdata_nxt  = mdata_r;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;

    case (state_r)
      ssgd_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ssgd_pkg::ST_DISPATCH;
        end
      end

      ssgd_pkg::ST_DISPATCH: begin
        case (cmd_r)
          ssgd_pkg::CMD_PREDICT, ssgd_pkg::CMD_OBSERVE: begin
            if (cmd_r == ssgd_pkg::CMD_OBSERVE && obs_drop) begin
              // stale snapshot or frozen: drop the observation
              ok_nxt    = 1'b0;
              state_nxt = ssgd_pkg::ST_DONE;
            end else begin
              mul_start = 1'b1;
              mneg_nxt  = x_r[DATA_WIDTH-1] ^ weight_r[DATA_WIDTH-1];
              msh_nxt   = ssgd_pkg::SH_FRAC;
              mdata_nxt = 1'b1;
              ret_nxt   = ssgd_pkg::ST_PRED_ADD;
              state_nxt = ssgd_pkg::ST_MUL_WAIT;
            end
          end
          ssgd_pkg::CMD_UPDATE: begin
            if (upd_skip) begin
              ok_nxt    = 1'b0;
              state_nxt = ssgd_pkg::ST_DONE;
            end else begin
              // weight decay term
              mul_start = 1'b1;
              mneg_nxt  = weight_r[DATA_WIDTH-1];
              msh_nxt   = ssgd_pkg::SH_RATE;
              mdata_nxt = 1'b0;
              ret_nxt   = ssgd_pkg::ST_GW;
              state_nxt = ssgd_pkg::ST_MUL_WAIT;
            end
          end
          default: begin
            // restart: load start values and clear the batch
            weight_nxt = start_weight_r;
            bias_nxt   = start_bias_r;
            count_nxt  = '0;
            wsum_nxt   = '0;
            bsum_nxt   = '0;
            ok_nxt     = 1'b1;
            state_nxt  = ssgd_pkg::ST_DONE;
          end
        endcase
      end

      ssgd_pkg::ST_MUL_WAIT: begin
        if (mul_done) begin
          t_nxt     = msat;
          state_nxt = ret_r;
        end
      end

      ssgd_pkg::ST_PRED_ADD: begin
        t_nxt = add_res;
        if (cmd_r == ssgd_pkg::CMD_PREDICT) begin
          ok_nxt    = 1'b1;
          state_nxt = ssgd_pkg::ST_DONE;
        end else begin
          state_nxt = ssgd_pkg::ST_ERR;
        end
      end

      ssgd_pkg::ST_ERR: begin
        err_nxt   = add_res[DATA_WIDTH-1:0];
        state_nxt = ssgd_pkg::ST_DW_START;
      end

      ssgd_pkg::ST_DW_START: begin
        // weight gradient -2*xc*err, i.e. shift one less and negate
        mul_start = 1'b1;
        mneg_nxt  = ~(xc[DATA_WIDTH-1] ^ err_r[DATA_WIDTH-1]);
        msh_nxt   = ssgd_pkg::SH_FRAC_M1;
        mdata_nxt = 1'b0;
        ret_nxt   = ssgd_pkg::ST_WSUM;
        state_nxt = ssgd_pkg::ST_MUL_WAIT;
      end

      ssgd_pkg::ST_WSUM: begin
        wsum_nxt  = add_res;
        state_nxt = ssgd_pkg::ST_DB;
      end

      ssgd_pkg::ST_DB: begin
        t_nxt     = add_res;
        state_nxt = ssgd_pkg::ST_BSUM;
      end

      ssgd_pkg::ST_BSUM: begin
        bsum_nxt = add_res;
        if (count_r != '1) begin
          count_nxt = count_r + CW'(1);
        end
        ok_nxt    = 1'b1;
        state_nxt = ssgd_pkg::ST_DONE;
      end

      ssgd_pkg::ST_GW, ssgd_pkg::ST_GB: begin
        t_nxt     = add_res;
        state_nxt = (state_r == ssgd_pkg::ST_GW) ? ssgd_pkg::ST_DIVW_START
                                                 : ssgd_pkg::ST_DIVB_START;
      end

      ssgd_pkg::ST_DIVW_START, ssgd_pkg::ST_DIVB_START: begin
        div_start = 1'b1;
        ret_nxt   = (state_r == ssgd_pkg::ST_DIVW_START) ? ssgd_pkg::ST_STW
                                                         : ssgd_pkg::ST_STB;
        state_nxt = ssgd_pkg::ST_DIV_WAIT;
      end

      ssgd_pkg::ST_DIV_WAIT: begin
        // quotient truncates toward zero: apply the dividend's sign
        if (div_done) begin
          t_nxt     = t_r[SW-1] ? -$signed(div_quot) : $signed(div_quot);
          state_nxt = ret_r;
        end
      end

      ssgd_pkg::ST_STW, ssgd_pkg::ST_STB: begin
        mul_start = 1'b1;
        mneg_nxt  = t_r[SW-1];
        msh_nxt   = ssgd_pkg::SH_RATE;
        mdata_nxt = 1'b0;
        ret_nxt   = (state_r == ssgd_pkg::ST_STW) ? ssgd_pkg::ST_WNEW
                                                  : ssgd_pkg::ST_BNEW;
        state_nxt = ssgd_pkg::ST_MUL_WAIT;
      end

      ssgd_pkg::ST_WNEW: begin
        weight_nxt = add_res[DATA_WIDTH-1:0];
        state_nxt  = ssgd_pkg::ST_BDEC;
      end

      ssgd_pkg::ST_BDEC: begin
        // bias decay term
        mul_start = 1'b1;
        mneg_nxt  = bias_r[DATA_WIDTH-1];
        msh_nxt   = ssgd_pkg::SH_RATE;
        mdata_nxt = 1'b0;
        ret_nxt   = ssgd_pkg::ST_GB;
        state_nxt = ssgd_pkg::ST_MUL_WAIT;
      end

      ssgd_pkg::ST_BNEW: begin
        bias_nxt  = add_res[DATA_WIDTH-1:0];
        count_nxt = '0;
        wsum_nxt  = '0;
        bsum_nxt  = '0;
        ok_nxt    = 1'b1;
        state_nxt = ssgd_pkg::ST_DONE;
      end

      ssgd_pkg::ST_DONE: begin
        // hold until the result register is free or being drained
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ssgd_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = ssgd_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control and model state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ssgd_pkg::ST_IDLE;
      ret_r       <= ssgd_pkg::ST_IDLE;
      weight_r    <= '0;
      bias_r      <= '0;
      count_r     <= '0;
      wsum_r      <= '0;
      bsum_r      <= '0;
      ok_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      weight_r    <= weight_nxt;
      bias_r      <= bias_nxt;
      count_r     <= count_nxt;
      wsum_r      <= wsum_nxt;
      bsum_r      <= bsum_nxt;
      ok_r        <= ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working payload
  always_ff @(posedge clk) begin
    t_r     <= t_nxt;
    err_r   <= err_nxt;
    mneg_r  <= mneg_nxt;
    msh_r   <= msh_nxt;
    mdata_r <= mdata_nxt;
  end

  // capture the input transfer
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= ssgd_pkg::cmd_t'(in_command);
      x_r   <= in_sample_x;
      sw_r  <= in_snap_weight;
      sb_r  <= in_snap_bias;
      act_r <= in_actual_value;
    end
  end

  // result register; predicted reads zero except for predict
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pred_r <= (cmd_r == ssgd_pkg::CMD_PREDICT) ? t_r[DATA_WIDTH-1:0] : '0;
      out_w_r    <= weight_r;
      out_b_r    <= bias_r;
      out_ok_r   <= ok_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_predicted  = out_pred_r;
  assign out_weight_now = out_w_r;
  assign out_bias_now   = out_b_r;
  assign out_accepted   = out_ok_r;

endmodule

@@ hdl/ssgd_mul.sv @@
// ============================================================================
// ssgd_mul - bit-serial shift-add multiplier
// Unsigned magnitudes; one multiplier bit retired per cycle through a shift
// register that fills with the low product bits.
// ============================================================================
module ssgd_mul #(
  parameter int DATA_WIDTH = ssgd_pkg::DATA_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  ssgd_pkg::mul_req_t                     req,
  input  logic [ssgd_pkg::SUM_W-1:0]             a_mag,
  input  logic [DATA_WIDTH-1:0]                  b_mag,
  output logic                                   done,
  output logic [ssgd_pkg::SUM_W+DATA_WIDTH-1:0]  product
);

  localparam int CNT_W = $clog2(DATA_WIDTH + 1);
  localparam int PW    = ssgd_pkg::SUM_W + DATA_WIDTH;

  logic [ssgd_pkg::SUM_W-1:0] hi_r;
  logic [DATA_WIDTH-1:0]      lo_r;
  logic [ssgd_pkg::SUM_W-1:0] a_r;
  logic [CNT_W-1:0]           cnt_r;
  logic                       busy_r;
  logic                       done_r;
  logic                       short_r;
  logic [ssgd_pkg::SUM_W:0]   step_sum;

  assign step_sum = {1'b0, hi_r} + (lo_r[0] ? {1'b0, a_r} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.short_op ? CNT_W'(ssgd_pkg::RATE_W) : CNT_W'(DATA_WIDTH);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      hi_r    <= '0;
      lo_r    <= b_mag;
      a_r     <= a_mag;
      short_r <= req.short_op;
    end else if (busy_r) begin
      hi_r <= step_sum[ssgd_pkg::SUM_W:1];
      lo_r <= {step_sum[0], lo_r[DATA_WIDTH-1:1]};
    end
  end

  // A short run leaves the unused multiplier bits (zero) below the product.
  assign product = short_r ? PW'({hi_r, lo_r[DATA_WIDTH-1 -: ssgd_pkg::RATE_W]})
                           : {hi_r, lo_r};
  assign done    = done_r;

endmodule

@@ hdl/ssgd_div.sv @@
// ============================================================================
// ssgd_div - restoring divider, one quotient bit per cycle
// Divides a 64-bit magnitude by a nonzero 32-bit count.
// ============================================================================
module ssgd_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [ssgd_pkg::SUM_W-1:0]   dividend,
  input  logic [ssgd_pkg::COUNT_W-1:0] divisor,
  output logic                         done,
  output logic [ssgd_pkg::SUM_W-1:0]   quotient
);

  localparam int CNT_W = $clog2(ssgd_pkg::SUM_W + 1);

  logic [ssgd_pkg::SUM_W-1:0]   num_r;
  logic [ssgd_pkg::COUNT_W-1:0] rem_r;
  logic [ssgd_pkg::COUNT_W-1:0] den_r;
  logic [CNT_W-1:0]             cnt_r;
  logic                         busy_r;
  logic                         done_r;
  logic [ssgd_pkg::COUNT_W:0]   trial;
  logic [ssgd_pkg::COUNT_W:0]   diff;
  logic                         fits;

  assign trial = {rem_r, num_r[ssgd_pkg::SUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(ssgd_pkg::SUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? diff[ssgd_pkg::COUNT_W-1:0] : trial[ssgd_pkg::COUNT_W-1:0];
      num_r <= {num_r[ssgd_pkg::SUM_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = num_r;

endmodule
